// File: design/signed_int_to_radix_digits_defines.svh
// assertion macros used by the top design file
`ifndef SIGNED_INT_TO_RADIX_DIGITS_DEFINES_SVH
`define SIGNED_INT_TO_RADIX_DIGITS_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define SIRD_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication, checked outside reset
`define SIRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SIRD_ASSERT_SAME(label, clk, rst, ante, cons)
`define SIRD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: design/sird_pkg.sv
`timescale 1ns / 1ps

package sird_pkg;

  // largest radix the alphabet may hold
  localparam int MAX_RADIX = 16;

  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] PRINT_FIRST = 8'd32;
  localparam logic [7:0] PRINT_LAST  = 8'd126;

  // register indexes of the configuration port
  typedef enum logic [1:0] {
    REG_RADIX_LENGTH  = 2'd0,
    REG_ALPHABET_LOW  = 2'd1,
    REG_ALPHABET_HIGH = 2'd2,
    REG_UNUSED        = 2'd3
  } sird_reg_t;

  localparam logic [4:0]  RESET_RADIX_LENGTH  = 5'd10;
  localparam logic [63:0] RESET_ALPHABET_LOW  = 64'h3736353433323130;
  localparam logic [63:0] RESET_ALPHABET_HIGH = 64'h4645444342413938;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CORR,
    ST_SIGN,
    ST_EMIT,
    ST_ERR
  } sird_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load_in;
    logic mul;
    logic corr;
    logic put_sign;
    logic put_digit;
    logic put_err;
  } sird_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic alpha_ok;
    logic div_done;
    logic neg;
    logic ptr_zero;
    logic out_free;
  } sird_stat_t;

  // character at a given alphabet position
  function automatic logic [7:0] alpha_char(input logic [63:0] lo, input logic [63:0] hi,
                                            input logic [3:0] pos);
    logic [63:0] word;
    word = pos[3] ? hi : lo;
    return word[{pos[2:0], 3'b000} +: 8];
  endfunction

  // floor(2^32 / d): quotient estimate is exact or one short
  function automatic logic [31:0] recip(input logic [4:0] d);
    logic [31:0] m;
    unique case (d)
      5'd2:    m = 32'h8000_0000;
      5'd3:    m = 32'h5555_5555;
      5'd4:    m = 32'h4000_0000;
      5'd5:    m = 32'h3333_3333;
      5'd6:    m = 32'h2AAA_AAAA;
      5'd7:    m = 32'h2492_4924;
      5'd8:    m = 32'h2000_0000;
      5'd9:    m = 32'h1C71_C71C;
      5'd10:   m = 32'h1999_9999;
      5'd11:   m = 32'h1745_D174;
      5'd12:   m = 32'h1555_5555;
      5'd13:   m = 32'h13B1_3B13;
      5'd14:   m = 32'h1249_2492;
      5'd15:   m = 32'h1111_1111;
      5'd16:   m = 32'h1000_0000;
      default: m = 32'h0000_0000;
    endcase
    return m;
  endfunction

endpackage

// File: design/sird_cfg.sv
`timescale 1ns / 1ps

module sird_cfg import sird_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output logic [4:0]  radix_length,
  output logic [63:0] alphabet_low,
  output logic [63:0] alphabet_high,
  output logic        alpha_ok
);

  logic [7:0] chars [MAX_RADIX];

  assign cfg_ready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      radix_length  <= RESET_RADIX_LENGTH;
      alphabet_low  <= RESET_ALPHABET_LOW;
      alphabet_high <= RESET_ALPHABET_HIGH;
    end else if (cfg_valid && cfg_ready) begin
      unique case (sird_reg_t'(cfg_index))
        REG_RADIX_LENGTH:  radix_length  <= cfg_data[4:0];
        REG_ALPHABET_LOW:  alphabet_low  <= cfg_data;
        REG_ALPHABET_HIGH: alphabet_high <= cfg_data;
        REG_UNUSED:        ;
      endcase
    end
  end

  // characters in alphabet order
  always_comb begin
    for (int i = 0; i < MAX_RADIX; i++) begin
      chars[i] = alpha_char(alphabet_low, alphabet_high, 4'(i));
    end
  end

  // alphabet check: radix range, printable, no signs, no duplicates
  always_comb begin
    alpha_ok = (radix_length >= 5'd2) && (radix_length <= 5'(MAX_RADIX));
    for (int a = 0; a < MAX_RADIX; a++) begin
      if (5'(a) < radix_length) begin
        if (chars[a] == CHAR_PLUS || chars[a] == CHAR_MINUS ||
            chars[a] < PRINT_FIRST || chars[a] > PRINT_LAST) begin
          alpha_ok = 1'b0;
        end
        for (int b = a + 1; b < MAX_RADIX; b++) begin
          if (5'(b) < radix_length && chars[a] == chars[b]) begin
            alpha_ok = 1'b0;
          end
        end
      end
    end
  end

endmodule

// File: design/sird_ctrl.sv
`timescale 1ns / 1ps

module sird_ctrl import sird_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  sird_stat_t  stat,
  output sird_cmd_t   cmd,
  output sird_state_t state
);

  sird_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_MUL;
      ST_MUL:  state_next = stat.alpha_ok ? ST_CORR : ST_ERR;
      ST_CORR: begin
        if (stat.div_done) begin
          state_next = stat.neg ? ST_SIGN : ST_EMIT;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_SIGN: if (stat.out_free) state_next = ST_EMIT;
      ST_EMIT: if (stat.out_free && stat.ptr_zero) state_next = ST_IDLE;
      ST_ERR:  if (stat.out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      ST_MUL:  cmd.mul       = 1'b1;
      ST_CORR: cmd.corr      = 1'b1;
      ST_SIGN: cmd.put_sign  = stat.out_free;
      ST_EMIT: cmd.put_digit = stat.out_free;
      ST_ERR:  cmd.put_err   = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// File: design/sird_dp.sv
`timescale 1ns / 1ps

module sird_dp import sird_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] value,
  input  logic [4:0]  radix_length,
  input  logic [63:0] alphabet_low,
  input  logic [63:0] alphabet_high,
  input  logic        alpha_ok,
  input  sird_cmd_t   cmd,
  output sird_stat_t  stat,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  char_out,
  output logic        last_char,
  output logic        bad_alphabet
);

  logic [31:0] mag;
  logic        neg;
  logic [31:0] prod_hi;
  logic [63:0] prod;
  logic [5:0]  nd;
  logic [4:0]  ptr;
  logic [3:0]  digits [32];

  logic [10:0] qd;
  logic [5:0]  rem0;
  logic        fix;
  logic [31:0] q;
  logic [3:0]  rem;
  logic        load_out;

  // quotient estimate from reciprocal, then one correction step
  assign prod = 64'(mag) * 64'(recip(radix_length));
  assign qd   = 11'(prod_hi[5:0]) * 11'(radix_length);
  assign rem0 = mag[5:0] - qd[5:0];
  assign fix  = rem0 >= 6'(radix_length);
  assign q    = prod_hi + 32'(fix);
  assign rem  = fix ? 4'(rem0 - 6'(radix_length)) : rem0[3:0];

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      neg <= value[31];
      mag <= value[31] ? (~value + 32'd1) : value;
      nd  <= '0;
    end
    if (cmd.mul) begin
      prod_hi <= prod[63:32];
    end
    if (cmd.corr) begin
      digits[nd[4:0]] <= rem;
      mag             <= q;
      nd              <= nd + 6'd1;
      ptr             <= nd[4:0];
    end
    if (cmd.put_digit) begin
      ptr <= ptr - 5'd1;
    end
  end

  assign load_out = cmd.put_sign || cmd.put_digit || cmd.put_err;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      priority if (cmd.put_err) begin
        char_out     <= 8'd0;
        last_char    <= 1'b1;
        bad_alphabet <= 1'b1;
      end else if (cmd.put_sign) begin
        char_out     <= CHAR_MINUS;
        last_char    <= 1'b0;
        bad_alphabet <= 1'b0;
      end else begin
        char_out     <= alpha_char(alphabet_low, alphabet_high, digits[ptr]);
        last_char    <= ptr == 5'd0;
        bad_alphabet <= 1'b0;
      end
    end
  end

  // status back to the controller
  always_comb begin
    stat.alpha_ok = alpha_ok;
    stat.div_done = (q == 32'd0) || (nd == 6'd31);
    stat.neg      = neg;
    stat.ptr_zero = ptr == 5'd0;
    stat.out_free = !out_valid || !out_stall;
  end

endmodule

// File: design/signed_int_to_radix_digits.sv
`timescale 1ns / 1ps
`include "signed_int_to_radix_digits_defines.svh"

// Converts one signed 32-bit value per item into its characters in the configured
// radix, most significant digit first, with a leading '-' for negatives and last_char
// set on the final character; an invalid alphabet gives one item with bad_alphabet set,
// char_out 0 and last_char 1. Each digit takes one reciprocal multiply (ST_MUL) and
// one correction step (ST_CORR); an item has 1 to 32 digits, and output stalls make
// it last longer. The input is stalled until the last character of the item is
// loaded; that character sits in an output register, so the next value is taken while
// it waits. The user is bound: Configuration is written only while idle; the block itself does not enforce it.
module signed_int_to_radix_digits import sird_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  char_out,
  output logic        last_char,
  output logic        bad_alphabet,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [4:0]  radix_length;
  logic [63:0] alphabet_low;
  logic [63:0] alphabet_high;
  logic        alpha_ok;
  sird_cmd_t   cmd;
  sird_stat_t  stat;
  sird_state_t state;

  // configuration registers and alphabet check
  sird_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .radix_length  (radix_length),
    .alphabet_low  (alphabet_low),
    .alphabet_high (alphabet_high),
    .alpha_ok      (alpha_ok)
  );

  // sequencer
  sird_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd),
    .state    (state)
  );

  // division, digit store and output register
  sird_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .value         (value),
    .radix_length  (radix_length),
    .alphabet_low  (alphabet_low),
    .alphabet_high (alphabet_high),
    .alpha_ok      (alpha_ok),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .char_out      (char_out),
    .last_char     (last_char),
    .bad_alphabet  (bad_alphabet)
  );

  // an accepted item keeps the input stalled on the next cycle
  `SIRD_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  // error item has a fixed form
  `SIRD_ASSERT_SAME(a_err_form, clk, rst, out_valid && bad_alphabet, last_char && char_out == 8'd0)
  // a finished division is followed by the sign or the digit emission
  `SIRD_ASSERT_NEXT(a_corr_then_out, clk, rst, state == ST_CORR && stat.div_done, state == ST_SIGN || state == ST_EMIT)

endmodule

// File: dv/radix_digits_checker.sv
`timescale 1ns / 1ps

module radix_digits_checker import sird_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  char_out,
  input  logic        last_char,
  input  logic        bad_alphabet,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int unsigned mismatches,
  output int unsigned owed
);

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       bad;
  } radix_char_t;

  // shadow copy of the configuration registers
  logic [4:0]   radix;
  logic [127:0] alphabet;

  // characters still to come, oldest first
  radix_char_t owed_chars[$];

  function automatic logic [7:0] glyph(input int unsigned pos);
    return alphabet[pos*8 +: 8];
  endfunction

  // radix in range, every character in use printable, unsigned and distinct
  function automatic bit alphabet_usable();
    logic [7:0] c;
    if (radix < 2 || radix > MAX_RADIX) return 1'b0;
    for (int a = 0; a < radix; a++) begin
      c = glyph(a);
      if (c == CHAR_PLUS || c == CHAR_MINUS) return 1'b0;
      if (c < PRINT_FIRST || c > PRINT_LAST) return 1'b0;
      for (int b = a + 1; b < radix; b++)
        if (glyph(b) == c) return 1'b0;
    end
    return 1'b1;
  endfunction

  // split one value into its characters, most significant digit first
  function automatic void predict_chars(input logic [31:0] v);
    logic [31:0] mag;
    logic [4:0]  digs[32];
    int          n;
    if (!alphabet_usable()) begin
      owed_chars.push_back(radix_char_t'{8'h00, 1'b1, 1'b1});
      return;
    end
    mag = v[31] ? -v : v;
    n = 0;
    do begin
      digs[n] = 5'(mag % radix);
      mag = mag / radix;
      n++;
    end while (mag != 0 && n < 32);
    if (v[31])
      owed_chars.push_back(radix_char_t'{CHAR_MINUS, 1'b0, 1'b0});
    for (int k = n - 1; k >= 0; k--)
      owed_chars.push_back(radix_char_t'{glyph(digs[k]), k == 0, 1'b0});
  endfunction

  always @(posedge clk) begin
    radix_char_t want;
    if (rst) begin
      radix = RESET_RADIX_LENGTH;
      alphabet = {RESET_ALPHABET_HIGH, RESET_ALPHABET_LOW};
      owed_chars.delete();
    end else begin
      // compare each emitted character with the oldest one owed
      if (out_valid && !out_stall) begin
        if (owed_chars.size() == 0) begin
          $error("unexpected item: char_out %02h last_char %0b bad_alphabet %0b",
                 char_out, last_char, bad_alphabet);
          mismatches++;
        end else begin
          want = owed_chars.pop_front();
          if (char_out !== want.ch) begin
            $error("char_out: expected %02h, got %02h", want.ch, char_out);
            mismatches++;
          end
          if (last_char !== want.last) begin
            $error("last_char: expected %0b, got %0b", want.last, last_char);
            mismatches++;
          end
          if (bad_alphabet !== want.bad) begin
            $error("bad_alphabet: expected %0b, got %0b", want.bad, bad_alphabet);
            mismatches++;
          end
        end
      end

      // register writes
      if (cfg_valid && cfg_ready) begin
        case (sird_reg_t'(cfg_index))
          REG_RADIX_LENGTH:  radix = cfg_data[4:0];
          REG_ALPHABET_LOW:  alphabet[63:0] = cfg_data;
          REG_ALPHABET_HIGH: alphabet[127:64] = cfg_data;
          default: ;
        endcase
      end

      // new value accepted
      if (in_valid && !in_stall)
        predict_chars(value);
    end
    owed = owed_chars.size();
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import sird_pkg::*;

  localparam int BATCHES        = 30;
  localparam int BATCH_LEN      = 12;
  localparam int FAULT_LEN      = 4;
  localparam int IDLE_PCT       = 37;
  localparam int HOLD_AT        = 80;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 110;

  typedef enum {FAULT_RADIX, FAULT_REPEAT, FAULT_SIGN, FAULT_UNPRINTABLE} fault_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  char_out;
  logic        last_char;
  logic        bad_alphabet;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  int unsigned mismatches;
  int unsigned owed;
  int unsigned items_sent = 0;
  int unsigned stuck = 0;
  bit          jitter = 1'b1;
  bit          hold = 1'b0;

  always #6 clk = ~clk;

  signed_int_to_radix_digits uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .char_out     (char_out),
    .last_char    (last_char),
    .bad_alphabet (bad_alphabet),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  radix_digits_checker chk (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .char_out     (char_out),
    .last_char    (last_char),
    .bad_alphabet (bad_alphabet),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .owed         (owed)
  );

  // receiver back-pressure
  always @(negedge clk) begin
    if (hold)
      out_stall = 1'b1;
    else if (jitter)
      out_stall = ($urandom_range(99) < IDLE_PCT);
    else
      out_stall = 1'b0;
  end

  // long receiver hold-off while values keep coming
  initial begin
    wait (items_sent >= HOLD_AT);
    @(negedge clk);
    hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold = 1'b0;
  end

  // give up when nothing moves on any channel for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      stuck = 0;
    else
      stuck++;
    if (stuck >= WATCHDOG_LIMIT) begin
      $display("[signed_int_to_radix_digits] ERROR");
      $finish;
    end
  end

  // alphabet from a string, padded with a filler byte
  function automatic logic [127:0] spell(input string s, input logic [7:0] fill);
    logic [127:0] a;
    for (int i = 0; i < 16; i++)
      a[i*8 +: 8] = (i < s.len()) ? s[i] : fill;
    return a;
  endfunction

  // distinct printable characters without sign marks, random bytes above
  function automatic logic [127:0] random_alphabet(input int n);
    logic [127:0] a;
    logic [7:0]   c;
    bit           taken;
    a = {$urandom, $urandom, $urandom, $urandom};
    for (int i = 0; i < n; i++) begin
      do begin
        c = 8'($urandom_range(PRINT_LAST, PRINT_FIRST));
        taken = (c == CHAR_PLUS || c == CHAR_MINUS);
        for (int j = 0; j < i; j++)
          if (a[j*8 +: 8] == c) taken = 1'b1;
      end while (taken);
      a[i*8 +: 8] = c;
    end
    return a;
  endfunction

  // value mix: full range, small, around powers of the radix, extremes
  function automatic logic [31:0] pick_value(input int n);
    logic [31:0] p;
    case ($urandom_range(5))
      0, 1: return $urandom;
      2: return $urandom_range(n * n);
      3: return -($urandom_range(n * n));
      4: begin
        p = 1;
        repeat ($urandom_range(31, 1)) p = p * n;
        p = p + $urandom_range(2) - 1;
        return $urandom_range(1) ? -p : p;
      end
      default: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0000_0000;
        endcase
      end
    endcase
  endfunction

  task automatic send_value(input logic [31:0] v);
    while (jitter && $urandom_range(99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    value = v;
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
  endtask

  // stop offering and wait for every owed character
  task automatic drain();
    in_valid = 1'b0;
    while (owed != 0) @(negedge clk);
  endtask

  task automatic write_reg(input sird_reg_t idx, input logic [63:0] d);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // radix write carries random upper bits, which the block drops
  task automatic set_alphabet(input logic [4:0] n, input logic [127:0] a);
    logic [63:0] d;
    drain();
    d = {$urandom, $urandom};
    d[4:0] = n;
    write_reg(REG_RADIX_LENGTH, d);
    write_reg(REG_ALPHABET_LOW, a[63:0]);
    write_reg(REG_ALPHABET_HIGH, a[127:64]);
  endtask

  initial begin
    logic [127:0] a;
    int           n;
    int           i;
    int           j;
    int           len;
    fault_t       fault;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // decimal after reset: zero, unit, extremes, small negative
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'hFFFF_FFFF);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
    send_value(-32'sd10);

    // binary, sign marks in the unused bytes are ignored
    drain();
    write_reg(REG_UNUSED, {$urandom, $urandom});
    set_alphabet(5'd2, spell("01", CHAR_MINUS));
    send_value(32'h8000_0000);
    send_value(32'h7FFF_FFFF);
    send_value(32'hFFFF_FFFF);

    // radix 16 with the printable extremes as digits
    set_alphabet(5'd16, spell(" ~0123456789abcd", 8'h00));
    send_value(32'd0);
    send_value(-32'sd16);
    send_value(32'h8000_0000);

    // radix out of range
    set_alphabet(5'd0, spell("0123456789ABCDEF", 8'h00));
    send_value($urandom);
    set_alphabet(5'd1, spell("0123456789ABCDEF", 8'h00));
    send_value($urandom);
    set_alphabet(5'd17, spell("0123456789ABCDEF", 8'h00));
    send_value($urandom);
    set_alphabet(5'd31, spell("0123456789ABCDEF", 8'h00));
    send_value($urandom);

    // repeated digit, plus, minus, below and above the printable range
    set_alphabet(5'd4, spell("0120", 8'h41));
    send_value(32'd5);
    set_alphabet(5'd4, spell("0+12", 8'h41));
    send_value(32'd5);
    set_alphabet(5'd4, spell("01-2", 8'h41));
    send_value(32'd5);
    a = spell("0123", 8'h41);
    a[15:8] = 8'd31;
    set_alphabet(5'd4, a);
    send_value(32'd5);
    a[15:8] = 8'd127;
    set_alphabet(5'd4, a);
    send_value(32'd5);

    // unused bytes with non-printable garbage
    set_alphabet(5'd3, spell("xyz", 8'hFF));
    send_value(-32'sd7);
    send_value(32'd5);

    // random alphabets, mostly usable, with a stretch of no idling
    for (int b = 0; b < BATCHES; b++) begin
      n = $urandom_range(MAX_RADIX, 2);
      a = random_alphabet(n);
      len = BATCH_LEN;
      if ($urandom_range(9) == 0) begin
        len = FAULT_LEN;
        fault = fault_t'($urandom_range(3));
        i = $urandom_range(n - 1);
        case (fault)
          FAULT_RADIX:
            n = $urandom_range(1) ? $urandom_range(31, 17) : $urandom_range(1);
          FAULT_REPEAT: begin
            j = (i + $urandom_range(n - 1, 1)) % n;
            a[j*8 +: 8] = a[i*8 +: 8];
          end
          FAULT_SIGN:
            a[i*8 +: 8] = $urandom_range(1) ? CHAR_PLUS : CHAR_MINUS;
          default:
            a[i*8 +: 8] = 8'($urandom_range(1) ? $urandom_range(31)
                                               : $urandom_range(255, 127));
        endcase
      end
      set_alphabet(5'(n), a);
      jitter = (b < 6 || b > 8);
      for (int k = 0; k < len; k++)
        send_value(pick_value(n < 2 ? 2 : n));
    end
    jitter = 1'b1;

    // let the last characters arrive, then watch for strays
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && owed == 0)
      $display("[signed_int_to_radix_digits] OK");
    else
      $display("[signed_int_to_radix_digits] ERROR");
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/sird_pkg.sv
design/sird_cfg.sv
design/sird_ctrl.sv
design/sird_dp.sv
design/signed_int_to_radix_digits.sv
dv/radix_digits_checker.sv
dv/tb.sv
